>>> hdl/rdk_pkg.sv
package rdk_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int ANG_BITS     = 28;
   localparam int TRIG_BITS    = 30;
   localparam int CORDIC_STEPS = 28;
   localparam int SQRT_STEPS   = 32;
   localparam int QUO_BITS     = 33;
   localparam int DIV_LAT      = QUO_BITS + 2;
   localparam int NUM_W        = 66;
   localparam int DEN_W        = 47;
   localparam int CSR_AW       = 3;

   localparam logic signed [32:0] PI_Q      = 33'sd843314857;
   localparam logic signed [32:0] HALF_PI_Q = 33'sd421657428;
   localparam logic signed [33:0] INV_GAIN  = 34'sd652032874;

   localparam logic REG_OFFSET = 1'b0;
   localparam logic REG_BRANCH = 1'b1;

   typedef enum logic [1:0] {
      ST_SOLVED      = 2'd0,
      ST_NO_ASSEMBLY = 2'd1,
      ST_DEGENERATE  = 2'd2
   } status_type;

   function automatic logic signed [32:0] atan_q(logic [4:0] i);
      logic signed [32:0] r;
      case (i)
         5'd0:  r = 33'sd210828714;
         5'd1:  r = 33'sd124459457;
         5'd2:  r = 33'sd65760959;
         5'd3:  r = 33'sd33381290;
         5'd4:  r = 33'sd16755422;
         5'd5:  r = 33'sd8385879;
         5'd6:  r = 33'sd4193963;
         5'd7:  r = 33'sd2097109;
         5'd8:  r = 33'sd1048571;
         5'd9:  r = 33'sd524287;
         5'd10: r = 33'sd262144;
         5'd11: r = 33'sd131072;
         5'd12: r = 33'sd65536;
         5'd13: r = 33'sd32768;
         5'd14: r = 33'sd16384;
         5'd15: r = 33'sd8192;
         5'd16: r = 33'sd4096;
         5'd17: r = 33'sd2048;
         5'd18: r = 33'sd1024;
         5'd19: r = 33'sd512;
         5'd20: r = 33'sd256;
         5'd21: r = 33'sd128;
         5'd22: r = 33'sd64;
         5'd23: r = 33'sd32;
         5'd24: r = 33'sd16;
         5'd25: r = 33'sd8;
         5'd26: r = 33'sd4;
         5'd27: r = 33'sd2;
         default: r = 33'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(logic signed [79:0] v);
      logic signed [31:0] r;
      if (v > 80'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -80'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // rounded half up, floor shift, saturated
   function automatic logic signed [31:0] mul_round(logic signed [65:0] p, int sh);
      logic signed [79:0] t;
      t = 80'(p) + (80'sd1 <<< (sh - 1));
      return sat32(t >>> sh);
   endfunction

endpackage

>>> hdl/rdk_div.sv
module rdk_div (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [rdk_pkg::NUM_W-1:0]   num,
   input  logic        [rdk_pkg::DEN_W-1:0]   den,
   output logic signed [31:0]                 quo
);

   localparam int QB    = rdk_pkg::QUO_BITS;
   localparam int CMP_W = rdk_pkg::DEN_W + QB;

   typedef struct packed {
      logic [CMP_W-1:0]          rem;
      logic [rdk_pkg::DEN_W-1:0] d;
      logic                      neg;
      logic                      big;
      logic [QB-1:0]             q;
   } dstage_type;

   dstage_type        st_ff [0:QB];
   dstage_type        st_in [0:QB];
   logic signed [31:0] quo_ff, quo_in;

   always_comb begin
      logic [rdk_pkg::NUM_W-1:0] mag;
      logic [CMP_W-1:0]          n0;
      logic [CMP_W-1:0]          dsh;
      mag = num[rdk_pkg::NUM_W-1] ? rdk_pkg::NUM_W'(-num) : rdk_pkg::NUM_W'(num);
      n0  = CMP_W'(mag) + CMP_W'(den >> 1);
      st_in[0].rem = n0;
      st_in[0].d   = den;
      st_in[0].neg = num[rdk_pkg::NUM_W-1];
      st_in[0].big = n0 >= (CMP_W'(den) << QB);
      st_in[0].q   = '0;
      for (int k = 0; k < QB; k++) begin
         st_in[k+1] = st_ff[k];
         dsh = CMP_W'(st_ff[k].d) << (QB - 1 - k);
         if (st_ff[k].rem >= dsh) begin
            st_in[k+1].rem          = st_ff[k].rem - dsh;
            st_in[k+1].q[QB-1-k]    = 1'b1;
         end
      end
      if (st_ff[QB].neg) begin
         if (st_ff[QB].big || st_ff[QB].q > (QB'(1) << 31)) begin
            quo_in = 32'sh8000_0000;
         end else begin
            quo_in = -$signed(st_ff[QB].q[31:0]);
         end
      end else begin
         if (st_ff[QB].big || st_ff[QB].q > QB'(32'h7FFF_FFFF)) begin
            quo_in = 32'sh7FFF_FFFF;
         end else begin
            quo_in = $signed(st_ff[QB].q[31:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= QB; k++) begin
            st_ff[k] <= st_in[k];
         end
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

>>> hdl/rpr_dyad_kinematics_top.sv
// channel | direction | handshake          | payload
// req     | in        | req_valid/req_stall | pa, pb, va, vb, aa, ab (x, y)
// rsp     | out       | rsp_valid/rsp_stall | status, slide and link values
// csr     | in        | psel/penable/pready | offset_length, branch_plus
//
// One transfer accepted per cycle while no stalled result holds the pipeline.
// The pipeline holds a 32-step root, two 28-step CORDICs and two pairs of 35-stage dividers.
// Synchronous reset clears valid bits and the registers; payload is not reset.
// A stalled result holds the whole pipeline; req_stall follows rsp_stall then.
module rpr_dyad_kinematics_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [31:0]            req_pa_x,
   input  logic signed [31:0]            req_pa_y,
   input  logic signed [31:0]            req_pb_x,
   input  logic signed [31:0]            req_pb_y,
   input  logic signed [31:0]            req_va_x,
   input  logic signed [31:0]            req_va_y,
   input  logic signed [31:0]            req_vb_x,
   input  logic signed [31:0]            req_vb_y,
   input  logic signed [31:0]            req_aa_x,
   input  logic signed [31:0]            req_aa_y,
   input  logic signed [31:0]            req_ab_x,
   input  logic signed [31:0]            req_ab_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [30:0]                   rsp_slide_length,
   output logic signed [31:0]            rsp_slide_speed,
   output logic signed [31:0]            rsp_slide_accel,
   output logic signed [31:0]            rsp_link_angle,
   output logic signed [31:0]            rsp_link_rate,
   output logic signed [31:0]            rsp_link_accel,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rdk_pkg::CSR_AW-1:0]    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   localparam int VEC_W    = 48;
   localparam int VEC_NORM = 40;
   localparam int NS       = rdk_pkg::CORDIC_STEPS;
   localparam int SS       = rdk_pkg::SQRT_STEPS;
   localparam int DL       = rdk_pkg::DIV_LAT;
   localparam int QSH      = rdk_pkg::TRIG_BITS - rdk_pkg::FRAC_BITS;

   typedef struct packed {
      logic               vld;
      logic               cant;
      logic               degen;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic [31:0]        r2;
      logic signed [31:0] lang;
      logic signed [33:0] ct;
      logic signed [33:0] st;
      logic signed [31:0] w;
      logic signed [31:0] vr;
   } item_type;

   typedef struct packed {
      item_type           it;
      logic signed [65:0] p0;
      logic signed [65:0] p1;
      logic signed [65:0] p2;
      logic signed [65:0] p3;
   } prd_type;

   typedef struct packed {
      item_type it;
      logic [63:0] n;
      logic [63:0] res;
   } sq_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [32:0]      z;
      logic                    zero;
   } vlane_type;

   typedef struct packed {
      item_type  it;
      vlane_type ph;
      vlane_type al;
      logic [5:0] kp;
      logic [5:0] ka;
   } vec_type;

   typedef struct packed {
      item_type           it;
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [32:0] z;
      logic               neg;
   } rot_type;

   typedef struct packed {
      item_type                         it;
      logic signed [rdk_pkg::NUM_W-1:0] n0;
      logic signed [rdk_pkg::NUM_W-1:0] n1;
      logic [rdk_pkg::DEN_W-1:0]        d0;
      logic [rdk_pkg::DEN_W-1:0]        d1;
   } num_type;

   function automatic logic signed [31:0] diff_sat(logic signed [31:0] a, logic signed [31:0] b);
      logic signed [32:0] d;
      logic signed [31:0] r;
      d = 33'(b) - 33'(a);
      if (d > 33'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (d < -33'sd2147483647) begin
         r = -32'sh7FFF_FFFF;
      end else begin
         r = d[31:0];
      end
      return r;
   endfunction

   function automatic sq_type sq_step(sq_type s, int k);
      sq_type      r;
      logic [63:0] bitv;
      logic [64:0] trial;
      bitv  = 64'(1) << (2 * (SS - 1 - k));
      trial = {1'b0, s.res} + {1'b0, bitv};
      r = s;
      if ({1'b0, s.n} >= trial) begin
         r.n   = s.n - trial[63:0];
         r.res = (s.res >> 1) + bitv;
      end else begin
         r.res = s.res >> 1;
      end
      return r;
   endfunction

   function automatic logic [5:0] norm_shift(vlane_type l);
      logic [VEC_W-1:0] ay;
      logic [39:0]      m;
      logic [5:0]       k;
      ay = l.y[VEC_W-1] ? VEC_W'(-l.y) : VEC_W'(l.y);
      m  = l.x[39:0] | ay[39:0];
      k  = '0;
      for (int j = 0; j < VEC_NORM; j++) begin
         if (m[j]) begin
            k = 6'(VEC_NORM - j);
         end
      end
      return k;
   endfunction

   function automatic vlane_type vec_step(vlane_type l, int i);
      vlane_type           r;
      logic signed [VEC_W-1:0] xs;
      logic signed [VEC_W-1:0] ys;
      xs = l.x >>> i;
      ys = l.y >>> i;
      r  = l;
      if (l.y > 0) begin
         r.x = l.x + ys;
         r.y = l.y - xs;
         r.z = l.z + rdk_pkg::atan_q(5'(i));
      end else begin
         r.x = l.x - ys;
         r.y = l.y + xs;
         r.z = l.z - rdk_pkg::atan_q(5'(i));
      end
      return r;
   endfunction

   function automatic rot_type rot_step(rot_type s, int i);
      rot_type            r;
      logic signed [33:0] xs;
      logic signed [33:0] ys;
      xs = s.x >>> i;
      ys = s.y >>> i;
      r  = s;
      if (s.z >= 0) begin
         r.x = s.x - ys;
         r.y = s.y + xs;
         r.z = s.z - rdk_pkg::atan_q(5'(i));
      end else begin
         r.x = s.x + ys;
         r.y = s.y - xs;
         r.z = s.z + rdk_pkg::atan_q(5'(i));
      end
      return r;
   endfunction

   logic        en;
   logic [30:0] offset_ff;
   logic        branch_ff;

   item_type s1_ff, s1_in;
   prd_type  s2_ff, s2_in;
   sq_type   sq_ff [0:SS];
   sq_type   sq_in [0:SS];
   vec_type  v0_ff, v0_in, v1_ff, v1_in;
   vec_type  vc_ff [0:NS];
   vec_type  vc_in [0:NS];
   rot_type  th_ff, th_in;
   rot_type  rc_ff [0:NS];
   rot_type  rc_in [0:NS];
   prd_type  p1_ff, p1_in;
   num_type  p2_ff, p2_in;
   item_type dl1_ff [0:DL-1];
   prd_type  m1_ff, m1_in, m2_ff, m2_in, m3_ff, m3_in, m4_ff, m4_in;
   prd_type  m5_ff, m5_in, m6_ff, m6_in;
   num_type  m7_ff, m7_in;
   item_type dl2_ff [0:DL-1];

   logic signed [31:0] w_q, vr_q, e_q, ar_q;

   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [30:0]        rsp_len_ff, rsp_len_in;
   logic signed [31:0] rsp_speed_ff, rsp_speed_in;
   logic signed [31:0] rsp_sacc_ff, rsp_sacc_in;
   logic signed [31:0] rsp_angle_ff, rsp_angle_in;
   logic signed [31:0] rsp_rate_ff, rsp_rate_in;
   logic signed [31:0] rsp_lacc_ff, rsp_lacc_in;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;
   assign pready    = 1'b1;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         branch_ff <= 1'b0;
      end else if (psel && penable && pwrite) begin
         case (paddr[2])
            rdk_pkg::REG_OFFSET: offset_ff <= pwdata[30:0];
            rdk_pkg::REG_BRANCH: branch_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         rdk_pkg::REG_OFFSET: prdata = {1'b0, offset_ff};
         rdk_pkg::REG_BRANCH: prdata = {31'b0, branch_ff};
         default:             prdata = '0;
      endcase
   end

   // differences, squares, root
   always_comb begin
      s1_in     = '0;
      s1_in.vld = req_valid;
      s1_in.dx  = diff_sat(req_pa_x, req_pb_x);
      s1_in.dy  = diff_sat(req_pa_y, req_pb_y);
      s1_in.vx  = diff_sat(req_va_x, req_vb_x);
      s1_in.vy  = diff_sat(req_va_y, req_vb_y);
      s1_in.ax  = diff_sat(req_aa_x, req_ab_x);
      s1_in.ay  = diff_sat(req_aa_y, req_ab_y);

      s2_in.it = s1_ff;
      s2_in.p0 = s1_ff.dx * s1_ff.dx;
      s2_in.p1 = s1_ff.dy * s1_ff.dy;
      s2_in.p2 = $signed({35'b0, offset_ff}) * $signed({35'b0, offset_ff});
      s2_in.p3 = '0;
   end

   always_comb begin
      logic signed [65:0] diff;
      diff           = s2_ff.p0 + s2_ff.p1 - s2_ff.p2;
      sq_in[0].it    = s2_ff.it;
      sq_in[0].it.cant = diff < 0;
      sq_in[0].n     = diff[63:0];
      sq_in[0].res   = '0;
      for (int k = 0; k < SS; k++) begin
         sq_in[k+1] = sq_step(sq_ff[k], k);
      end
   end

   // vectoring for phi and alpha
   always_comb begin
      item_type it;
      it       = sq_ff[SS].it;
      it.r2    = sq_ff[SS].res[31:0];
      v0_in    = '0;
      v0_in.it = it;
      v0_in.ph.x    = VEC_W'(it.dx);
      v0_in.ph.y    = VEC_W'(it.dy);
      v0_in.ph.z    = '0;
      v0_in.ph.zero = (it.dx == 0) && (it.dy == 0);
      if (it.dx < 0) begin
         v0_in.ph.z = (it.dy >= 0) ? rdk_pkg::PI_Q : -rdk_pkg::PI_Q;
         v0_in.ph.x = -VEC_W'(it.dx);
         v0_in.ph.y = -VEC_W'(it.dy);
      end
      v0_in.al.x    = $signed(VEC_W'(it.r2));
      v0_in.al.y    = $signed(VEC_W'(offset_ff));
      v0_in.al.z    = '0;
      v0_in.al.zero = (it.r2 == 0) && (offset_ff == 0);

      v1_in    = v0_ff;
      v1_in.kp = norm_shift(v0_ff.ph);
      v1_in.ka = norm_shift(v0_ff.al);

      vc_in[0]      = v1_ff;
      vc_in[0].ph.x = v1_ff.ph.x <<< v1_ff.kp;
      vc_in[0].ph.y = v1_ff.ph.y <<< v1_ff.kp;
      vc_in[0].al.x = v1_ff.al.x <<< v1_ff.ka;
      vc_in[0].al.y = v1_ff.al.y <<< v1_ff.ka;
      for (int k = 0; k < NS; k++) begin
         vc_in[k+1]    = vc_ff[k];
         vc_in[k+1].ph = vec_step(vc_ff[k].ph, k);
         vc_in[k+1].al = vec_step(vc_ff[k].al, k);
      end
   end

   // theta, then rotation for cos and sin
   always_comb begin
      logic signed [32:0] phi;
      logic signed [32:0] alpha;
      logic signed [32:0] theta;
      logic signed [32:0] z;
      logic               neg;
      phi   = vc_ff[NS].ph.zero ? 33'sd0 : vc_ff[NS].ph.z;
      alpha = vc_ff[NS].al.zero ? 33'sd0 : vc_ff[NS].al.z;
      theta = branch_ff ? phi + alpha : phi - alpha;
      th_in          = '0;
      th_in.it       = vc_ff[NS].it;
      th_in.it.degen = vc_ff[NS].it.r2 == 0;
      th_in.it.lang  = 32'((theta + (33'sd1 <<< (rdk_pkg::ANG_BITS - rdk_pkg::FRAC_BITS - 1)))
                           >>> (rdk_pkg::ANG_BITS - rdk_pkg::FRAC_BITS));
      th_in.z        = theta;

      z   = th_ff.z;
      neg = 1'b0;
      for (int j = 0; j < 2; j++) begin
         if (z > rdk_pkg::HALF_PI_Q) begin
            z   = z - rdk_pkg::PI_Q;
            neg = !neg;
         end else if (z < -rdk_pkg::HALF_PI_Q) begin
            z   = z + rdk_pkg::PI_Q;
            neg = !neg;
         end
      end
      rc_in[0].it  = th_ff.it;
      rc_in[0].x   = rdk_pkg::INV_GAIN;
      rc_in[0].y   = '0;
      rc_in[0].z   = z;
      rc_in[0].neg = neg;
      for (int k = 0; k < NS; k++) begin
         rc_in[k+1] = rot_step(rc_ff[k], k);
      end
   end

   // rate and slide speed
   always_comb begin
      item_type it;
      it    = rc_ff[NS].it;
      it.ct = rc_ff[NS].neg ? -rc_ff[NS].x : rc_ff[NS].x;
      it.st = rc_ff[NS].neg ? -rc_ff[NS].y : rc_ff[NS].y;
      p1_in.it = it;
      p1_in.p0 = it.vy * it.ct;
      p1_in.p1 = it.vx * it.st;
      p1_in.p2 = it.vy * it.dy;
      p1_in.p3 = it.vx * it.dx;

      p2_in.it = p1_ff.it;
      p2_in.n0 = p1_ff.p0 - p1_ff.p1;
      p2_in.n1 = p1_ff.p2 + p1_ff.p3;
      p2_in.d0 = rdk_pkg::DEN_W'(p1_ff.it.r2) << QSH;
      p2_in.d1 = rdk_pkg::DEN_W'(p1_ff.it.r2);
   end

   rdk_div u_div_w (
      .clock (clock),
      .en    (en),
      .num   (p2_ff.n0),
      .den   (p2_ff.d0),
      .quo   (w_q)
   );

   rdk_div u_div_vr (
      .clock (clock),
      .en    (en),
      .num   (p2_ff.n1),
      .den   (p2_ff.d1),
      .quo   (vr_q)
   );

   // accelerations
   always_comb begin
      item_type           it;
      logic signed [31:0] w2;
      logic signed [31:0] wv;
      logic signed [31:0] ea;
      logic signed [31:0] fa;
      it    = dl1_ff[DL-1];
      it.w  = w_q;
      it.vr = vr_q;
      m1_in.it = it;
      m1_in.p0 = it.w * it.w;
      m1_in.p1 = it.w * it.vr;
      m1_in.p2 = '0;
      m1_in.p3 = '0;

      m2_in    = m1_ff;
      m2_in.p0 = 66'(rdk_pkg::mul_round(m1_ff.p0, rdk_pkg::FRAC_BITS));
      m2_in.p1 = 66'(rdk_pkg::mul_round(m1_ff.p1, rdk_pkg::FRAC_BITS));

      w2 = m2_ff.p0[31:0];
      wv = m2_ff.p1[31:0];
      m3_in.it = m2_ff.it;
      m3_in.p0 = w2 * m2_ff.it.dx;
      m3_in.p1 = w2 * m2_ff.it.dy;
      m3_in.p2 = wv * m2_ff.it.st;
      m3_in.p3 = wv * m2_ff.it.ct;

      m4_in.it = m3_ff.it;
      m4_in.p0 = 66'(rdk_pkg::mul_round(m3_ff.p0, rdk_pkg::FRAC_BITS));
      m4_in.p1 = 66'(rdk_pkg::mul_round(m3_ff.p1, rdk_pkg::FRAC_BITS));
      m4_in.p2 = 66'(rdk_pkg::mul_round(m3_ff.p2, rdk_pkg::TRIG_BITS - 1));
      m4_in.p3 = 66'(rdk_pkg::mul_round(m3_ff.p3, rdk_pkg::TRIG_BITS - 1));

      m5_in    = m4_ff;
      m5_in.p0 = 66'(rdk_pkg::sat32(80'(m4_ff.it.ax) + 80'(m4_ff.p0) + 80'(m4_ff.p2)));
      m5_in.p1 = 66'(rdk_pkg::sat32(80'(m4_ff.it.ay) + 80'(m4_ff.p1) - 80'(m4_ff.p3)));

      ea = m5_ff.p0[31:0];
      fa = m5_ff.p1[31:0];
      m6_in.it = m5_ff.it;
      m6_in.p0 = fa * m5_ff.it.ct;
      m6_in.p1 = ea * m5_ff.it.st;
      m6_in.p2 = ea * m5_ff.it.dx;
      m6_in.p3 = fa * m5_ff.it.dy;

      m7_in.it = m6_ff.it;
      m7_in.n0 = m6_ff.p0 - m6_ff.p1;
      m7_in.n1 = m6_ff.p2 + m6_ff.p3;
      m7_in.d0 = rdk_pkg::DEN_W'(m6_ff.it.r2) << QSH;
      m7_in.d1 = rdk_pkg::DEN_W'(m6_ff.it.r2);
   end

   rdk_div u_div_e (
      .clock (clock),
      .en    (en),
      .num   (m7_ff.n0),
      .den   (m7_ff.d0),
      .quo   (e_q)
   );

   rdk_div u_div_ar (
      .clock (clock),
      .en    (en),
      .num   (m7_ff.n1),
      .den   (m7_ff.d1),
      .quo   (ar_q)
   );

   // result
   always_comb begin
      item_type it;
      logic     ok;
      it = dl2_ff[DL-1];
      ok = !it.cant && !it.degen;
      if (it.cant) begin
         rsp_status_in = rdk_pkg::ST_NO_ASSEMBLY;
      end else if (it.degen) begin
         rsp_status_in = rdk_pkg::ST_DEGENERATE;
      end else begin
         rsp_status_in = rdk_pkg::ST_SOLVED;
      end
      if (!ok) begin
         rsp_len_in = '0;
      end else if (it.r2[31]) begin
         rsp_len_in = 31'h7FFF_FFFF;
      end else begin
         rsp_len_in = it.r2[30:0];
      end
      rsp_speed_in = ok ? it.vr : 32'sd0;
      rsp_sacc_in  = ok ? ar_q : 32'sd0;
      rsp_angle_in = it.cant ? 32'sd0 : it.lang;
      rsp_rate_in  = ok ? it.w : 32'sd0;
      rsp_lacc_in  = ok ? e_q : 32'sd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.vld    <= 1'b0;
         s2_ff.it.vld <= 1'b0;
         for (int k = 0; k <= SS; k++) begin
            sq_ff[k].it.vld <= 1'b0;
         end
         v0_ff.it.vld <= 1'b0;
         v1_ff.it.vld <= 1'b0;
         for (int k = 0; k <= NS; k++) begin
            vc_ff[k].it.vld <= 1'b0;
            rc_ff[k].it.vld <= 1'b0;
         end
         th_ff.it.vld <= 1'b0;
         p1_ff.it.vld <= 1'b0;
         p2_ff.it.vld <= 1'b0;
         for (int k = 0; k < DL; k++) begin
            dl1_ff[k].vld <= 1'b0;
            dl2_ff[k].vld <= 1'b0;
         end
         m1_ff.it.vld <= 1'b0;
         m2_ff.it.vld <= 1'b0;
         m3_ff.it.vld <= 1'b0;
         m4_ff.it.vld <= 1'b0;
         m5_ff.it.vld <= 1'b0;
         m6_ff.it.vld <= 1'b0;
         m7_ff.it.vld <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         for (int k = 0; k <= SS; k++) begin
            sq_ff[k] <= sq_in[k];
         end
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         for (int k = 0; k <= NS; k++) begin
            vc_ff[k] <= vc_in[k];
            rc_ff[k] <= rc_in[k];
         end
         th_ff     <= th_in;
         p1_ff     <= p1_in;
         p2_ff     <= p2_in;
         dl1_ff[0] <= p2_ff.it;
         dl2_ff[0] <= m7_ff.it;
         for (int k = 1; k < DL; k++) begin
            dl1_ff[k] <= dl1_ff[k-1];
            dl2_ff[k] <= dl2_ff[k-1];
         end
         m1_ff <= m1_in;
         m2_ff <= m2_in;
         m3_ff <= m3_in;
         m4_ff <= m4_in;
         m5_ff <= m5_in;
         m6_ff <= m6_in;
         m7_ff <= m7_in;
         rsp_valid_ff <= dl2_ff[DL-1].vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_status_ff <= rsp_status_in;
         rsp_len_ff    <= rsp_len_in;
         rsp_speed_ff  <= rsp_speed_in;
         rsp_sacc_ff   <= rsp_sacc_in;
         rsp_angle_ff  <= rsp_angle_in;
         rsp_rate_ff   <= rsp_rate_in;
         rsp_lacc_ff   <= rsp_lacc_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slide_length = rsp_len_ff;
   assign rsp_slide_speed  = rsp_speed_ff;
   assign rsp_slide_accel  = rsp_sacc_ff;
   assign rsp_link_angle   = rsp_angle_ff;
   assign rsp_link_rate    = rsp_rate_ff;
   assign rsp_link_accel   = rsp_lacc_ff;

endmodule

>>> hdl/rdk_chk.sv
module rdk_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [1:0]         rsp_status,
   input logic [30:0]        rsp_slide_length,
   input logic signed [31:0] rsp_slide_speed,
   input logic signed [31:0] rsp_slide_accel,
   input logic signed [31:0] rsp_link_angle,
   input logic signed [31:0] rsp_link_rate,
   input logic signed [31:0] rsp_link_accel
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_link_angle) && $stable(rsp_slide_length))
      else $error("stalled result changed");

   // input stalls only behind a stalled result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == rdk_pkg::ST_SOLVED || rsp_status == rdk_pkg::ST_NO_ASSEMBLY
         || rsp_status == rdk_pkg::ST_DEGENERATE)
      else $error("bad status code");

   a_unsolved_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != rdk_pkg::ST_SOLVED |-> rsp_slide_length == 0
         && rsp_slide_speed == 0 && rsp_slide_accel == 0 && rsp_link_rate == 0
         && rsp_link_accel == 0)
      else $error("unsolved result carries motion values");

   a_no_assembly_angle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rdk_pkg::ST_NO_ASSEMBLY |-> rsp_link_angle == 0)
      else $error("angle given without assembly");

endmodule

bind rpr_dyad_kinematics_top rdk_chk u_rdk_chk (.*);
